>>> sv/bltf_pkg.sv
// bltf_pkg: shared types and constants of the backlight timeout and fade controller
// no dependencies; imported by bltf_cfg, bltf_core, the top level and the bench
package bltf_pkg;

    // light modes as seen on the light_mode result field
    typedef enum logic [1:0] {
        MODE_ON     = 2'd0,
        MODE_TIMED  = 2'd1,
        MODE_FADING = 2'd2,
        MODE_OFF    = 2'd3
    } mode_t;

    // event codes carried by the command field
    typedef enum logic [3:0] {
        CMD_TICK           = 4'd0,
        CMD_PRESS          = 4'd1,
        CMD_RELEASE        = 4'd2,
        CMD_INTERACTION    = 4'd3,
        CMD_ENABLE         = 4'd4,
        CMD_ENABLE_RESPECT = 4'd5,
        CMD_RESET_USER     = 4'd6,
        CMD_RESET_TIMED    = 4'd7,
        CMD_TOGGLE_ENABLE  = 4'd8,
        CMD_TOGGLE_AMBIENT = 4'd9,
        CMD_ALLOW          = 4'd10
    } cmd_t;

    // register indexes on the configuration port
    localparam logic REG_ON_INTENSITY = 1'b0;
    localparam logic REG_TIMEOUT_MS   = 1'b1;

    // fixed timing and scaling constants
    localparam int FADE_TIME_MS   = 500;
    localparam int FADE_STEPS     = 20;
    localparam int POWER_SAVE_PCT = 25;
    localparam int PCT_DIV        = 100;
    localparam int MAX_BUTTONS    = 4;

    localparam logic [15:0] FADE_RESTART  = 16'(FADE_TIME_MS / FADE_STEPS);
    localparam logic [2:0]  BUTTONS_LIMIT = 3'(MAX_BUTTONS);

    // register reset values and their derived step and half levels
    localparam int ON_INTENSITY_RESET = 16384;
    localparam int TIMEOUT_MS_RESET   = 3000;
    localparam logic [15:0] ON_STEP_RESET = 16'(ON_INTENSITY_RESET / FADE_STEPS);
    localparam logic [15:0] ON_HALF_RESET = 16'(ON_INTENSITY_RESET / 2);

    // x / 20 as (x >> 2) / 5, with / 5 done as * 52429 >> 18 (exact below 2^16)
    localparam logic [15:0] RECIP_FIVE = 16'd52429;

    // configuration seen by the event logic
    typedef struct packed {
        logic [15:0] on_intensity;
        logic [15:0] timeout_ms;
        logic [15:0] on_step;
        logic [15:0] on_half;
    } cfg_t;

    // one result transaction
    typedef struct packed {
        logic [15:0] brightness;
        logic [1:0]  light_mode;
        logic        user_controlled;
        logic        above_half;
        logic        count_error;
    } res_t;

    // controller state
    typedef struct packed {
        mode_t       mode;
        logic [15:0] level;
        logic [15:0] timer_remaining;
        logic        timer_running;
        logic [2:0]  buttons_down;
        logic        forced_by_user;
        logic        light_permitted;
        logic        backlight_on_setting;
        logic        ambient_check_setting;
    } state_t;

endpackage

>>> sv/bltf_cfg.sv
// bltf_cfg: apb-style register file for on_intensity and timeout_ms
// also keeps the fade step and half level of on_intensity; depends on bltf_pkg
module bltf_cfg
    import bltf_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_t        cfg
);

    logic [15:0] on_intensity_reg;
    logic [15:0] timeout_ms_reg;
    logic [15:0] on_step_reg;
    logic [15:0] on_half_reg;
    logic        wr_en;
    logic [13:0] quarter;
    logic [29:0] recip_prod;
    logic [15:0] on_step_next;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    // fade step of the written intensity, reciprocal multiply for / 20
    assign quarter      = pwdata[15:2];
    assign recip_prod   = quarter * RECIP_FIVE;
    assign on_step_next = {4'd0, recip_prod[29:18]};

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            on_intensity_reg <= 16'(ON_INTENSITY_RESET);
            timeout_ms_reg   <= 16'(TIMEOUT_MS_RESET);
            on_step_reg      <= ON_STEP_RESET;
            on_half_reg      <= ON_HALF_RESET;
        end
        else if (wr_en)
        begin
            if (paddr[2] == REG_ON_INTENSITY)
            begin
                on_intensity_reg <= pwdata[15:0];
                on_step_reg      <= on_step_next;
                on_half_reg      <= {1'b0, pwdata[15:1]};
            end
            else
            begin
                timeout_ms_reg <= pwdata[15:0];
            end
        end
    end

    // register readback
    always_comb
    begin
        if (paddr[2] == REG_ON_INTENSITY)
            prdata = {16'd0, on_intensity_reg};
        else
            prdata = {16'd0, timeout_ms_reg};
    end

    assign cfg.on_intensity = on_intensity_reg;
    assign cfg.timeout_ms   = timeout_ms_reg;
    assign cfg.on_step      = on_step_reg;
    assign cfg.on_half      = on_half_reg;

endmodule

>>> sv/bltf_core.sv
// bltf_core: controller state and the combinational event update
// depends on bltf_pkg; state advances once per transaction taken by the top level
module bltf_core
    import bltf_pkg::*;
#(
    parameter int BRIGHT_MAX = 16384
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [3:0] command,
    input  logic       enable,
    input  logic       ambient_is_light,
    input  logic       power_save,
    input  cfg_t       cfg,
    output res_t       res
);

    // power-save intensity and its derived levels
    localparam logic [15:0] LP_INTENSITY = 16'((BRIGHT_MAX * POWER_SAVE_PCT) / PCT_DIV);
    localparam logic [15:0] LP_STEP      = 16'(((BRIGHT_MAX * POWER_SAVE_PCT) / PCT_DIV)
                                               / FADE_STEPS);
    localparam logic [15:0] LP_HALF      = 16'(((BRIGHT_MAX * POWER_SAVE_PCT) / PCT_DIV) / 2);

    state_t      st_reg;
    state_t      st_next;
    logic        err;
    logic [15:0] intensity;
    logic [15:0] step;
    logic [15:0] half;

    // mode entry: sets level and timer for the new mode
    function automatic state_t set_mode(state_t s, mode_t m, logic [15:0] inten,
                                        logic [15:0] stp, logic [15:0] tmo);
        state_t r;
        r      = s;
        r.mode = m;
        case (m)
            MODE_ON:
            begin
                r.level           = inten;
                r.timer_remaining = 16'd0;
                r.timer_running   = 1'b0;
            end
            MODE_TIMED:
            begin
                r.level           = inten;
                r.timer_remaining = tmo;
                r.timer_running   = 1'b1;
            end
            MODE_FADING:
            begin
                if (s.level <= stp)
                begin
                    r.level = 16'd0;
                    r.mode  = MODE_OFF;
                end
                else
                begin
                    r.level           = s.level - stp;
                    r.timer_remaining = FADE_RESTART;
                    r.timer_running   = 1'b1;
                end
            end
            default:
            begin
                r.level           = 16'd0;
                r.timer_remaining = 16'd0;
                r.timer_running   = 1'b0;
            end
        endcase
        return r;
    endfunction

    // permission to light up
    function automatic logic light_ok(state_t s, logic amb);
        logic ok;
        ok = s.light_permitted && s.backlight_on_setting;
        if (s.ambient_check_setting && s.level == 16'd0 && amb)
            ok = 1'b0;
        return ok;
    endfunction

    // active intensity follows power_save of this transaction
    always_comb
    begin
        if (power_save)
        begin
            intensity = LP_INTENSITY;
            step      = LP_STEP;
            half      = LP_HALF;
        end
        else
        begin
            intensity = cfg.on_intensity;
            step      = cfg.on_step;
            half      = cfg.on_half;
        end
    end

    // event update
    always_comb
    begin
        st_next = st_reg;
        err     = 1'b0;
        case (cmd_t'(command))
            CMD_TICK:
            begin
                if (st_next.timer_running)
                begin
                    if (st_next.timer_remaining <= 16'd1)
                    begin
                        st_next.timer_running   = 1'b0;
                        st_next.timer_remaining = 16'd0;
                        st_next = set_mode(st_next, MODE_FADING, intensity, step,
                                           cfg.timeout_ms);
                    end
                    else
                    begin
                        st_next.timer_remaining = st_next.timer_remaining - 16'd1;
                    end
                end
            end
            CMD_PRESS:
            begin
                if (st_next.buttons_down >= BUTTONS_LIMIT)
                begin
                    st_next.buttons_down = 3'd0;
                    err = 1'b1;
                end
                else
                begin
                    st_next.buttons_down = st_next.buttons_down + 3'd1;
                end
                if (light_ok(st_next, ambient_is_light))
                    st_next = set_mode(st_next, MODE_ON, intensity, step, cfg.timeout_ms);
            end
            CMD_RELEASE:
            begin
                if (st_next.buttons_down == 3'd0)
                    err = 1'b1;
                else
                    st_next.buttons_down = st_next.buttons_down - 3'd1;
                if (st_next.buttons_down == 3'd0 && st_next.mode == MODE_ON
                    && !st_next.forced_by_user)
                    st_next = set_mode(st_next, MODE_TIMED, intensity, step, cfg.timeout_ms);
            end
            CMD_INTERACTION:
            begin
                if (st_next.buttons_down == 3'd0 && st_next.mode != MODE_ON
                    && light_ok(st_next, ambient_is_light))
                    st_next = set_mode(st_next, MODE_TIMED, intensity, step, cfg.timeout_ms);
            end
            CMD_ENABLE:
            begin
                st_next.forced_by_user = enable;
                if (enable)
                    st_next = set_mode(st_next, MODE_ON, intensity, step, cfg.timeout_ms);
                else if (st_next.buttons_down == 3'd0)
                    st_next = set_mode(st_next, MODE_OFF, intensity, step, cfg.timeout_ms);
            end
            CMD_ENABLE_RESPECT:
            begin
                st_next.forced_by_user = enable;
                if (enable)
                begin
                    if (light_ok(st_next, ambient_is_light))
                        st_next = set_mode(st_next, MODE_ON, intensity, step,
                                           cfg.timeout_ms);
                end
                else if (st_next.buttons_down == 3'd0)
                begin
                    st_next = set_mode(st_next, MODE_OFF, intensity, step, cfg.timeout_ms);
                end
            end
            CMD_RESET_USER:
            begin
                if (st_next.forced_by_user)
                begin
                    st_next.forced_by_user = 1'b0;
                    if (st_next.buttons_down == 3'd0)
                        st_next = set_mode(st_next, MODE_OFF, intensity, step,
                                           cfg.timeout_ms);
                end
            end
            CMD_RESET_TIMED:
            begin
                if (st_next.forced_by_user)
                begin
                    st_next.forced_by_user = 1'b0;
                    if (light_ok(st_next, ambient_is_light))
                        st_next = set_mode(st_next, MODE_TIMED, intensity, step,
                                           cfg.timeout_ms);
                end
            end
            CMD_TOGGLE_ENABLE:
            begin
                st_next.backlight_on_setting = !st_next.backlight_on_setting;
                if (light_ok(st_next, ambient_is_light))
                    st_next = set_mode(st_next, MODE_TIMED, intensity, step, cfg.timeout_ms);
                else
                    st_next = set_mode(st_next, MODE_OFF, intensity, step, cfg.timeout_ms);
            end
            CMD_TOGGLE_AMBIENT:
            begin
                st_next.ambient_check_setting = !st_next.ambient_check_setting;
                if (light_ok(st_next, ambient_is_light) && !ambient_is_light)
                    st_next = set_mode(st_next, MODE_TIMED, intensity, step, cfg.timeout_ms);
                else
                    st_next = set_mode(st_next, MODE_OFF, intensity, step, cfg.timeout_ms);
            end
            CMD_ALLOW:
            begin
                if (st_next.light_permitted && !enable)
                    st_next = set_mode(st_next, MODE_OFF, intensity, step, cfg.timeout_ms);
                st_next.light_permitted = enable;
            end
            default:
            begin
                st_next = st_reg;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.mode                  <= MODE_OFF;
            st_reg.level                 <= 16'd0;
            st_reg.timer_remaining       <= 16'd0;
            st_reg.timer_running         <= 1'b0;
            st_reg.buttons_down          <= 3'd0;
            st_reg.forced_by_user        <= 1'b0;
            st_reg.light_permitted       <= 1'b0;
            st_reg.backlight_on_setting  <= 1'b1;
            st_reg.ambient_check_setting <= 1'b0;
        end
        else if (fire)
        begin
            st_reg <= st_next;
        end
    end

    // result of this transaction
    assign res.brightness      = st_next.level;
    assign res.light_mode      = 2'(st_next.mode);
    assign res.user_controlled = st_next.forced_by_user;
    assign res.above_half      = (st_next.level > half);
    assign res.count_error     = err;

`ifndef NO_ASSERTIONS
    a_buttons_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.buttons_down <= BUTTONS_LIMIT)
        else $error("button count above limit");

    a_off_is_dark: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.mode == MODE_OFF |-> st_reg.level == 16'd0)
        else $error("light off with nonzero level");

    a_timer_in_timed_modes: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg.timer_running == (st_reg.mode == MODE_TIMED || st_reg.mode == MODE_FADING))
        else $error("timer state does not match mode");

    a_stopped_timer_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        !st_reg.timer_running |-> st_reg.timer_remaining == 16'd0)
        else $error("stopped timer holds a count");

    a_state_holds_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !fire |=> $stable(st_reg))
        else $error("state changed without a transaction");
`endif

endmodule

>>> sv/backlight_timeout_fade_controller.sv
// backlight_timeout_fade_controller: top level with event input register and result register
// depends on bltf_pkg, bltf_cfg and bltf_core
//
// usage:
//   events come in on the evt channel (evt_valid / evt_stall) with command, enable,
//   ambient_is_light and power_save; each event gives exactly one result on the res
//   channel (res_valid / res_stall) with brightness, light_mode, user_controlled,
//   above_half and count_error.
//   on_intensity (address 0) and timeout_ms (address 4) are written over the apb-style
//   port, by the user only while no event is in flight (unenforced); pready is always high.
// pipeline and throughput:
//   an event taken is held in the event register; its result is registered in the
//   result register when the event advances, which a stalled result may hold off.
//   one event per cycle sustained while res_stall is low; the state update is
//   combinational logic between the event register and the result register.
// reset:
//   rst_n clears both channels, the mode becomes off with level zero, registers return
//   to 16384 and 3000.
// stalls:
//   while res_stall holds a result, the event register keeps its transaction and
//   evt_stall rises once it is full; nothing is lost or repeated.
module backlight_timeout_fade_controller
    import bltf_pkg::*;
#(
    parameter int BRIGHT_MAX = 16384
)
(
    input  logic        clk,
    input  logic        rst_n,
    // event channel
    input  logic        evt_valid,
    output logic        evt_stall,
    input  logic [3:0]  command,
    input  logic        enable,
    input  logic        ambient_is_light,
    input  logic        power_save,
    // result channel
    output logic        res_valid,
    input  logic        res_stall,
    output logic [15:0] brightness,
    output logic [1:0]  light_mode,
    output logic        user_controlled,
    output logic        above_half,
    output logic        count_error,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic        evt_valid_reg;
    logic [3:0]  command_reg;
    logic        enable_reg;
    logic        ambient_reg;
    logic        power_save_reg;
    logic        res_valid_reg;
    res_t        res_reg;
    res_t        res_next;
    cfg_t        cfg;
    logic        advance;
    logic        evt_take;

    // event register moves on when the result register is free or being drained
    assign advance   = evt_valid_reg && (!res_valid_reg || !res_stall);
    assign evt_stall = evt_valid_reg && !advance;
    assign evt_take  = evt_valid && !evt_stall;

    // event register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            evt_valid_reg <= 1'b0;
        else if (evt_take)
            evt_valid_reg <= 1'b1;
        else if (advance)
            evt_valid_reg <= 1'b0;
    end

    // event register payload
    always_ff @(posedge clk)
    begin
        if (evt_take)
        begin
            command_reg    <= command;
            enable_reg     <= enable;
            ambient_reg    <= ambient_is_light;
            power_save_reg <= power_save;
        end
    end

    // result register valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (advance)
            res_valid_reg <= 1'b1;
        else if (!res_stall)
            res_valid_reg <= 1'b0;
    end

    // result register payload
    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= res_next;
    end

    bltf_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    bltf_core #(
        .BRIGHT_MAX (BRIGHT_MAX)
    ) u_core (
        .clk              (clk),
        .rst_n            (rst_n),
        .fire             (advance),
        .command          (command_reg),
        .enable           (enable_reg),
        .ambient_is_light (ambient_reg),
        .power_save       (power_save_reg),
        .cfg              (cfg),
        .res              (res_next)
    );

    assign res_valid       = res_valid_reg;
    assign brightness      = res_reg.brightness;
    assign light_mode      = res_reg.light_mode;
    assign user_controlled = res_reg.user_controlled;
    assign above_half      = res_reg.above_half;
    assign count_error     = res_reg.count_error;

`ifndef NO_ASSERTIONS
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        advance |-> !(res_valid_reg && res_stall))
        else $error("result register overwritten while stalled");

    a_event_kept: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && !advance |=> evt_valid_reg && $stable(command_reg))
        else $error("pending event lost");

    a_result_follows_event: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> res_valid_reg)
        else $error("event advanced without a result");
`endif

endmodule

>>> bench/backlight_timeout_fade_controller_test.sv
// backlight_timeout_fade_controller_test: self-checking bench for the backlight controller
// depends on bltf_pkg and backlight_timeout_fade_controller; predicts every result in-line
// and checks it field by field under random idling, stalls and register settings
module backlight_timeout_fade_controller_test;
    import bltf_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int BRIGHT_MAX  = 16384;
    localparam int CYCLE_LIMIT = 200000;
    localparam int LONG_HOLD   = 150;
    localparam int SETTLE      = 6;

    // command codes the block ignores
    localparam logic [3:0] CMD_UNUSED_LO = 4'd11;
    localparam logic [3:0] CMD_UNUSED_HI = 4'd15;

    typedef struct packed {
        logic [3:0] command;
        logic       enable;
        logic       ambient;
        logic       power_save;
    } evt_t;

    // dut connections
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        evt_valid = 1'b0;
    logic        evt_stall;
    logic [3:0]  command = '0;
    logic        enable = 1'b0;
    logic        ambient_is_light = 1'b0;
    logic        power_save = 1'b0;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [15:0] brightness;
    logic [1:0]  light_mode;
    logic        user_controlled;
    logic        above_half;
    logic        count_error;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [2:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    // bench bookkeeping
    res_t expected_light[$];
    int   error_count = 0;
    int   cycle_count = 0;
    int   idle_pct = 0;
    int   stall_pct = 0;
    int   hold_asked = 0;
    int   hold_seen = 0;
    int   hold_left = 0;

    // predicted controller state and register copies
    mode_t       p_mode;
    logic [15:0] p_level;
    logic [15:0] p_timer;
    bit          p_timer_on;
    int unsigned p_buttons;
    bit          p_forced;
    bit          p_permitted;
    bit          p_bl_setting;
    bit          p_amb_check;
    logic [15:0] p_on_intensity;
    logic [15:0] p_timeout;
    bit          lp_now;
    bit          amb_now;

    backlight_timeout_fade_controller #(
        .BRIGHT_MAX(BRIGHT_MAX)
    ) u_top (
        .clk              (clk),
        .rst_n            (rst_n),
        .evt_valid        (evt_valid),
        .evt_stall        (evt_stall),
        .command          (command),
        .enable           (enable),
        .ambient_is_light (ambient_is_light),
        .power_save       (power_save),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .brightness       (brightness),
        .light_mode       (light_mode),
        .user_controlled  (user_controlled),
        .above_half       (above_half),
        .count_error      (count_error),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // receiver: random stalls plus an occasional long hold-off
    always @(posedge clk)
    begin
        if (hold_seen != hold_asked)
        begin
            hold_seen <= hold_asked;
            hold_left <= LONG_HOLD;
            res_stall <= 1'b1;
        end
        else if (hold_left != 0)
        begin
            hold_left <= hold_left - 1;
            res_stall <= 1'b1;
        end
        else
        begin
            res_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // result checker
    always @(posedge clk)
    begin
        res_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (expected_light.size() == 0)
            begin
                $error("result transaction with nothing expected");
                error_count++;
            end
            else
            begin
                want = expected_light.pop_front();
                if (brightness !== want.brightness)
                begin
                    $error("brightness: expected %0d, got %0d", want.brightness, brightness);
                    error_count++;
                end
                if (light_mode !== want.light_mode)
                begin
                    $error("light_mode: expected %0d, got %0d", want.light_mode, light_mode);
                    error_count++;
                end
                if (user_controlled !== want.user_controlled)
                begin
                    $error("user_controlled: expected %0d, got %0d",
                           want.user_controlled, user_controlled);
                    error_count++;
                end
                if (above_half !== want.above_half)
                begin
                    $error("above_half: expected %0d, got %0d", want.above_half, above_half);
                    error_count++;
                end
                if (count_error !== want.count_error)
                begin
                    $error("count_error: expected %0d, got %0d",
                           want.count_error, count_error);
                    error_count++;
                end
            end
        end
    end

    // intensity in force for the current transaction
    function automatic logic [15:0] drive_level();
        if (lp_now)
            return 16'(BRIGHT_MAX * POWER_SAVE_PCT / PCT_DIV);
        return p_on_intensity;
    endfunction

    // whether the light may be turned on now
    function automatic bit light_allowed();
        if (!p_permitted || !p_bl_setting)
            return 1'b0;
        if (p_amb_check)
            return !(p_level == 0 && amb_now);
        return 1'b1;
    endfunction

    // mode entry with its side effects on level and timer
    task automatic enter_mode(mode_t m);
        logic [15:0] step;
        p_mode = m;
        case (m)
            MODE_ON:
            begin
                p_level    = drive_level();
                p_timer    = '0;
                p_timer_on = 1'b0;
            end
            MODE_TIMED:
            begin
                p_level    = drive_level();
                p_timer    = p_timeout;
                p_timer_on = 1'b1;
            end
            MODE_FADING:
            begin
                step = 16'(drive_level() / FADE_STEPS);
                if (p_level <= step)
                begin
                    p_level = '0;
                    p_mode  = MODE_OFF;
                end
                else
                begin
                    p_level    = p_level - step;
                    p_timer    = 16'(FADE_TIME_MS / FADE_STEPS);
                    p_timer_on = 1'b1;
                end
            end
            default:
            begin
                p_level    = '0;
                p_timer    = '0;
                p_timer_on = 1'b0;
            end
        endcase
    endtask

    task automatic reset_prediction();
        p_mode         = MODE_OFF;
        p_level        = '0;
        p_timer        = '0;
        p_timer_on     = 1'b0;
        p_buttons      = 0;
        p_forced       = 1'b0;
        p_permitted    = 1'b0;
        p_bl_setting   = 1'b1;
        p_amb_check    = 1'b0;
        p_on_intensity = 16'd16384;
        p_timeout      = 16'd3000;
        lp_now         = 1'b0;
        amb_now        = 1'b0;
    endtask

    // next light state and result for one event
    task automatic predict_light(input evt_t e, output res_t r);
        bit fault;
        fault   = 1'b0;
        lp_now  = e.power_save;
        amb_now = e.ambient;
        case (e.command)
            CMD_TICK:
            begin
                if (p_timer_on)
                begin
                    if (p_timer <= 16'd1)
                    begin
                        p_timer    = '0;
                        p_timer_on = 1'b0;
                        enter_mode(MODE_FADING);
                    end
                    else
                    begin
                        p_timer = p_timer - 16'd1;
                    end
                end
            end
            CMD_PRESS:
            begin
                p_buttons++;
                if (p_buttons > MAX_BUTTONS)
                begin
                    p_buttons = 0;
                    fault     = 1'b1;
                end
                if (light_allowed())
                    enter_mode(MODE_ON);
            end
            CMD_RELEASE:
            begin
                if (p_buttons == 0)
                    fault = 1'b1;
                else
                    p_buttons--;
                if (p_buttons == 0 && p_mode == MODE_ON && !p_forced)
                    enter_mode(MODE_TIMED);
            end
            CMD_INTERACTION:
            begin
                if (p_buttons == 0 && p_mode != MODE_ON && light_allowed())
                    enter_mode(MODE_TIMED);
            end
            CMD_ENABLE:
            begin
                p_forced = e.enable;
                if (e.enable)
                    enter_mode(MODE_ON);
                else if (p_buttons == 0)
                    enter_mode(MODE_OFF);
            end
            CMD_ENABLE_RESPECT:
            begin
                p_forced = e.enable;
                if (e.enable)
                begin
                    if (light_allowed())
                        enter_mode(MODE_ON);
                end
                else if (p_buttons == 0)
                begin
                    enter_mode(MODE_OFF);
                end
            end
            CMD_RESET_USER:
            begin
                if (p_forced)
                begin
                    p_forced = 1'b0;
                    if (p_buttons == 0)
                        enter_mode(MODE_OFF);
                end
            end
            CMD_RESET_TIMED:
            begin
                if (p_forced)
                begin
                    p_forced = 1'b0;
                    if (light_allowed())
                        enter_mode(MODE_TIMED);
                end
            end
            CMD_TOGGLE_ENABLE:
            begin
                p_bl_setting = !p_bl_setting;
                enter_mode(light_allowed() ? MODE_TIMED : MODE_OFF);
            end
            CMD_TOGGLE_AMBIENT:
            begin
                p_amb_check = !p_amb_check;
                enter_mode((light_allowed() && !amb_now) ? MODE_TIMED : MODE_OFF);
            end
            CMD_ALLOW:
            begin
                if (p_permitted && !e.enable)
                    enter_mode(MODE_OFF);
                p_permitted = e.enable;
            end
            default:
            begin
            end
        endcase
        r.brightness      = p_level;
        r.light_mode      = p_mode;
        r.user_controlled = p_forced;
        r.above_half      = (p_level > drive_level() / 2);
        r.count_error     = fault;
    endtask

    // offer one event, wait for acceptance, queue its expected result
    task automatic send_event(evt_t e);
        res_t r;
        while ($urandom_range(99) < idle_pct)
        begin
            evt_valid <= 1'b0;
            @(posedge clk);
        end
        evt_valid        <= 1'b1;
        command          <= e.command;
        enable           <= e.enable;
        ambient_is_light <= e.ambient;
        power_save       <= e.power_save;
        do
            @(posedge clk);
        while (evt_stall);
        predict_light(e, r);
        expected_light.push_back(r);
    endtask

    task automatic send_cmd(logic [3:0] c, bit en, bit amb, bit ps);
        evt_t e;
        e.command    = c;
        e.enable     = en;
        e.ambient    = amb;
        e.power_save = ps;
        send_event(e);
    endtask

    // weighted random event, ticks dominate so timers expire and fades progress
    function automatic evt_t random_event();
        evt_t e;
        int   pick;
        pick         = $urandom_range(99);
        e.enable     = 1'($urandom_range(1));
        e.ambient    = 1'($urandom_range(1));
        e.power_save = ($urandom_range(99) < 15);
        if (pick < 45)
            e.command = CMD_TICK;
        else if (pick < 56)
            e.command = CMD_PRESS;
        else if (pick < 67)
            e.command = CMD_RELEASE;
        else if (pick < 75)
            e.command = CMD_INTERACTION;
        else if (pick < 78)
            e.command = CMD_ENABLE;
        else if (pick < 81)
            e.command = CMD_ENABLE_RESPECT;
        else if (pick < 84)
            e.command = CMD_RESET_USER;
        else if (pick < 87)
            e.command = CMD_RESET_TIMED;
        else if (pick < 90)
            e.command = CMD_TOGGLE_ENABLE;
        else if (pick < 93)
            e.command = CMD_TOGGLE_AMBIENT;
        else if (pick < 98)
        begin
            e.command = CMD_ALLOW;
            e.enable  = ($urandom_range(9) != 0);
        end
        else
        begin
            e.command = 4'($urandom_range(CMD_UNUSED_HI, CMD_UNUSED_LO));
        end
        return e;
    endfunction

    // setup then access phase; the register takes the value at the access edge
    task automatic write_reg(logic idx, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (idx == REG_ON_INTENSITY)
            p_on_intensity = value;
        else
            p_timeout = value;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        idle_pct  = send_pct;
        stall_pct <= recv_pct;
    endtask

    // stop offering and let every outstanding result drain
    task automatic wait_all_results();
        evt_valid <= 1'b0;
        while (expected_light.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // field extremes, every command and the named corner cases
    task automatic test_directed();
        set_idling(0, 0);
        write_reg(REG_TIMEOUT_MS, 16'd2);
        send_cmd(CMD_ALLOW, 1, 0, 0);
        send_cmd(CMD_PRESS, 0, 0, 0);
        send_cmd(CMD_PRESS, 0, 1, 1);
        send_cmd(CMD_PRESS, 1, 0, 0);
        send_cmd(CMD_PRESS, 0, 0, 0);
        // fifth held button overflows the count
        send_cmd(CMD_PRESS, 0, 0, 0);
        // release with nothing held underflows
        send_cmd(CMD_RELEASE, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 0);
        send_cmd(CMD_TICK, 0, 0, 0);
        send_cmd(CMD_INTERACTION, 0, 0, 1);
        send_cmd(CMD_ENABLE, 1, 0, 0);
        send_cmd(CMD_RELEASE, 0, 0, 0);
        send_cmd(CMD_RESET_TIMED, 0, 0, 0);
        send_cmd(CMD_ENABLE_RESPECT, 0, 0, 0);
        send_cmd(CMD_ENABLE_RESPECT, 1, 0, 0);
        send_cmd(CMD_RESET_USER, 0, 0, 0);
        // ambient check in bright surroundings while dark
        send_cmd(CMD_TOGGLE_AMBIENT, 0, 1, 0);
        send_cmd(CMD_PRESS, 0, 1, 0);
        send_cmd(CMD_PRESS, 0, 0, 0);
        send_cmd(CMD_TOGGLE_AMBIENT, 0, 0, 0);
        send_cmd(CMD_TOGGLE_ENABLE, 0, 0, 0);
        send_cmd(CMD_TOGGLE_ENABLE, 0, 0, 0);
        // ignored codes still give a result
        send_cmd(CMD_UNUSED_LO, 0, 0, 0);
        send_cmd(CMD_UNUSED_HI, 1, 1, 1);
        send_cmd(CMD_ALLOW, 0, 0, 0);
        wait_all_results();
    endtask

    // zero timeout and full intensity: expire on the first tick and fade down to off
    task automatic test_fade_to_off();
        evt_t e;
        write_reg(REG_ON_INTENSITY, 16'hFFFF);
        write_reg(REG_TIMEOUT_MS, 16'd0);
        set_idling(10, 10);
        send_cmd(CMD_ALLOW, 1, 0, 0);
        send_cmd(CMD_PRESS, 0, 0, 0);
        send_cmd(CMD_RELEASE, 0, 0, 0);
        repeat (540)
        begin
            e            = random_event();
            e.command    = CMD_TICK;
            e.power_save = ($urandom_range(99) < 5);
            send_event(e);
        end
        wait_all_results();
    endtask

    // long receiver hold-off while the sender keeps offering, then a full drain
    task automatic test_backpressure();
        set_idling(0, 0);
        write_reg(REG_TIMEOUT_MS, 16'd3);
        send_cmd(CMD_ALLOW, 1, 0, 0);
        hold_asked <= hold_asked + 1;
        repeat (30)
            send_event(random_event());
        wait_all_results();
        repeat (5)
            send_event(random_event());
        wait_all_results();
    endtask

    // random traffic under each idling pattern and register setting
    task automatic test_random_phases();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    write_reg(REG_ON_INTENSITY, 16'd0);
                    write_reg(REG_TIMEOUT_MS, 16'hFFFF);
                    set_idling(0, 0);
                end
                1:
                begin
                    write_reg(REG_ON_INTENSITY, 16'hFFFF);
                    write_reg(REG_TIMEOUT_MS, 16'd0);
                    set_idling(48, 0);
                end
                2:
                begin
                    write_reg(REG_ON_INTENSITY, 16'($urandom));
                    write_reg(REG_TIMEOUT_MS, 16'($urandom_range(40, 1)));
                    set_idling(0, 48);
                end
                default:
                begin
                    write_reg(REG_ON_INTENSITY, 16'($urandom_range(400)));
                    write_reg(REG_TIMEOUT_MS, 16'($urandom_range(40)));
                    set_idling(10, 10);
                end
            endcase
            send_cmd(CMD_ALLOW, 1, 1'($urandom_range(1)), 0);
            repeat (180)
                send_event(random_event());
            wait_all_results();
        end
    endtask

    // stimulus sequence
    initial
    begin
        reset_prediction();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fade_to_off();
        test_backpressure();
        test_random_phases();
        set_idling(0, 0);
        wait_all_results();
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

>>> filelist.f
sv/bltf_pkg.sv
sv/bltf_cfg.sv
sv/bltf_core.sv
sv/backlight_timeout_fade_controller.sv
bench/backlight_timeout_fade_controller_test.sv
